// ===== design/sec_pkg.sv =====
// Shared types and constants for the smooth escape color pipeline.
package sec_pkg;

  // Default number of fraction bits on the orbit coordinates.
  localparam int DEF_COORD_FRAC_BITS = 24;

  // Fraction bits of the fixed-point logarithms.
  localparam int LOG_FRAC = 16;

  // Reset values of the configuration registers.
  localparam logic [31:0] GAIN_RESET   = 32'h0100_0000;
  localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;

  // Pipeline depth: input squares, sum, normalize, two logarithm chains,
  // smooth count, two product stages and four palette stages.
  localparam int NUM_STAGES = 3 + LOG_FRAC + 1 + LOG_FRAC + 7;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_COLOR_GAIN   = 1'b0,
    REG_COLOR_OFFSET = 1'b1
  } cfg_reg_t;

endpackage

// ===== design/smooth_escape_color_core.sv =====
// Smooth escape-count palette pipeline: top level.
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+----------
//  in      | input     | in_iteration_count, in_z_real, in_z_imag     | in_valid/in_ready
//  out     | output    | out_red, out_green, out_blue,                | out_valid/out_ready
//          |           | out_magnitude_invalid                        |
//  cfg     | input     | cfg_index, cfg_data                          | cfg_valid/cfg_ready
//
// One pixel transaction is accepted per clock while the output is not stalled; each result passes
// through NUM_STAGES pipeline stages, a depth set mostly by the two 16-step squaring logarithm units.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// When a result waits at the output and out_ready is low, the whole pipeline holds;
// bubbles do not compress during a stall. The configuration port is always ready.
module smooth_escape_color_core
  import sec_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_iteration_count,
  input  logic [31:0] in_z_real,
  input  logic [31:0] in_z_imag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_magnitude_invalid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NSQ = LOG_FRAC;
  localparam logic [63:0] ONE_SQ    = 64'd1 << (2 * COORD_FRAC_BITS);
  localparam logic [21:0] LOG_SCALE = 22'((2 * COORD_FRAC_BITS) << LOG_FRAC);
  localparam logic [39:0] LL_BIAS   = 40'(17 << LOG_FRAC);

  // Index of the top set bit.
  function automatic logic [5:0] lead_idx(input logic [63:0] v);
    logic [5:0] idx;
    idx = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // Mantissa normalized to Q1.31 by truncation.
  function automatic logic [31:0] norm_mant(input logic [63:0] v, input logic [5:0] e);
    logic [63:0] t;
    t = v << (6'd63 - e);
    return t[63:32];
  endfunction

  // Q1.16 product, (a*b) >> 16.
  function automatic logic [16:0] mulq(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = a * b;
    return p[32:16];
  endfunction

  // Configuration registers.
  logic [31:0] gain_r, offset_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COLOR_GAIN:   gain_r   <= cfg_data;
        REG_COLOR_OFFSET: offset_r <= cfg_data;
        default:          gain_r   <= gain_r;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a finished result is stuck.
  logic adv;
  logic [NUM_STAGES:1] vld_r;

  assign adv       = !vld_r[NUM_STAGES] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NUM_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-1:1], in_valid};
    end
  end

  // Stage 1: magnitudes and their squares.
  logic [31:0] ar, ai;
  logic [63:0] sqr_r, sqi_r;
  logic [15:0] it1_r;

  assign ar = in_z_real[31] ? 32'(-in_z_real) : in_z_real;
  assign ai = in_z_imag[31] ? 32'(-in_z_imag) : in_z_imag;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqr_r <= ar * ar;
      sqi_r <= ai * ai;
      it1_r <= in_iteration_count;
    end
  end

  // Stage 2: squared magnitude and the unit-circle test.
  logic [63:0] m2_r;
  logic        inv2_r;
  logic [15:0] it2_r;
  logic [63:0] m2_sum;

  assign m2_sum = sqr_r + sqi_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r   <= m2_sum;
      inv2_r <= (m2_sum <= ONE_SQ);
      it2_r  <= it1_r;
    end
  end

  // Stage 3: first logarithm, exponent and normalized mantissa.
  logic [31:0] ma_r  [0:NSQ];
  logic [15:0] fa_r  [0:NSQ];
  logic [5:0]  ea_r  [0:NSQ];
  logic        inva_r[0:NSQ];
  logic [15:0] ita_r [0:NSQ];
  logic [5:0]  e_m2;

  assign e_m2 = lead_idx(m2_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_r[0]   <= norm_mant(m2_r, e_m2);
      fa_r[0]   <= '0;
      ea_r[0]   <= e_m2;
      inva_r[0] <= inv2_r;
      ita_r[0]  <= it2_r;
    end
  end

  // First logarithm: one fraction bit per squaring stage.
  for (genvar k = 0; k < NSQ; k++) begin : g_loga
    logic [63:0] sq;
    assign sq = ma_r[k] * ma_r[k];
    always_ff @(posedge clk) begin
      if (adv) begin
        ma_r[k+1]   <= sq[63] ? sq[63:32] : sq[62:31];
        fa_r[k+1]   <= {fa_r[k][14:0], sq[63]};
        ea_r[k+1]   <= ea_r[k];
        inva_r[k+1] <= inva_r[k];
        ita_r[k+1]  <= ita_r[k];
      end
    end
  end

  // Stage 20: log2 of |z|^2, saturated at one LSB, then normalized again.
  logic [31:0] mb_r  [0:NSQ];
  logic [15:0] fb_r  [0:NSQ];
  logic [4:0]  eb_r  [0:NSQ];
  logic        invb_r[0:NSQ];
  logic [15:0] itb_r [0:NSQ];
  logic [21:0] lg_raw, lg;
  logic [5:0]  e_lg;

  assign lg_raw = {ea_r[NSQ], fa_r[NSQ]} - LOG_SCALE;
  assign lg     = (inva_r[NSQ] || lg_raw == '0) ? 22'd1 : lg_raw;
  assign e_lg   = lead_idx({42'd0, lg});

  always_ff @(posedge clk) begin
    if (adv) begin
      mb_r[0]   <= norm_mant({42'd0, lg}, e_lg);
      fb_r[0]   <= '0;
      eb_r[0]   <= e_lg[4:0];
      invb_r[0] <= inva_r[NSQ];
      itb_r[0]  <= ita_r[NSQ];
    end
  end

  // Second logarithm, same squaring scheme.
  for (genvar k = 0; k < NSQ; k++) begin : g_logb
    logic [63:0] sq;
    assign sq = mb_r[k] * mb_r[k];
    always_ff @(posedge clk) begin
      if (adv) begin
        mb_r[k+1]   <= sq[63] ? sq[63:32] : sq[62:31];
        fb_r[k+1]   <= {fb_r[k][14:0], sq[63]};
        eb_r[k+1]   <= eb_r[k];
        invb_r[k+1] <= invb_r[k];
        itb_r[k+1]  <= itb_r[k];
      end
    end
  end

  // Stage 37: smooth count in Q.16, kept modulo 2^40.
  logic [39:0] s_r, s_base, s_val;
  logic        inv37_r;

  assign s_base = ({24'd0, itb_r[NSQ]} + 40'd1) << LOG_FRAC;
  assign s_val  = invb_r[NSQ] ? s_base
                : s_base + LL_BIAS - {19'd0, eb_r[NSQ], fb_r[NSQ]};

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r     <= s_val;
      inv37_r <= invb_r[NSQ];
    end
  end

  // Stage 38: gain product split into two partial products.
  logic [52:0] pp0;
  logic [39:0] pp1;
  logic [39:0] pp0_r;
  logic [19:0] pp1_r;
  logic        inv38_r;

  assign pp0 = 53'($signed({1'b0, s_r[19:0]}) * $signed(gain_r));
  assign pp1 = s_r[39:20] * gain_r[19:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      pp0_r   <= pp0[39:0];
      pp1_r   <= pp1[19:0];
      inv38_r <= inv37_r;
    end
  end

  // Stage 39: add the phase and wrap into the unit interval.
  logic [39:0] y;
  logic [16:0] x39_r, u39_r;
  logic        inv39_r;

  assign y = pp0_r + {pp1_r, 20'd0} + {offset_r[23:0], 16'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      x39_r   <= {1'b0, y[39:24]};
      u39_r   <= 17'h10000 - {1'b0, y[39:24]};
      inv39_r <= inv38_r;
    end
  end

  // Stages 40 to 42: the polynomial products.
  logic [16:0] xx_r, uu_r, x40_r, u40_r;
  logic [16:0] r2_r, g2_r, b2_r, x41_r, u41_r;
  logic [16:0] r3_r, g3_r, b3_r;
  logic        inv40_r, inv41_r, inv42_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx_r    <= mulq(x39_r, x39_r);
      uu_r    <= mulq(u39_r, u39_r);
      x40_r   <= x39_r;
      u40_r   <= u39_r;
      inv40_r <= inv39_r;
      r2_r    <= mulq(xx_r, x40_r);
      g2_r    <= mulq(xx_r, u40_r);
      b2_r    <= mulq(uu_r, u40_r);
      x41_r   <= x40_r;
      u41_r   <= u40_r;
      inv41_r <= inv40_r;
      r3_r    <= mulq(r2_r, u41_r);
      g3_r    <= mulq(g2_r, u41_r);
      b3_r    <= mulq(b2_r, x41_r);
      inv42_r <= inv41_r;
    end
  end

  // Stage 43: palette weights scaled to bytes.
  logic [29:0] rw, gw, bw;
  logic [7:0]  red_r, green_r, blue_r;
  logic        inv43_r;

  assign rw = r3_r * 13'd2295;
  assign gw = g3_r * 13'd3825;
  assign bw = b3_r * 13'd4335;

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= rw[23:16];
      green_r <= gw[23:16];
      blue_r  <= bw[24:17];
      inv43_r <= inv42_r;
    end
  end

  assign out_red               = red_r;
  assign out_green             = green_r;
  assign out_blue              = blue_r;
  assign out_magnitude_invalid = inv43_r;

endmodule

// ===== design/sec_checker.sv =====
// Port-level checker for the smooth escape color pipeline, with its bind.
module sec_checker
  import sec_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_magnitude_invalid,
  input logic        cfg_ready
);

  // A result held at the output keeps its value until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_magnitude_invalid))
    else $error("output transaction changed while stalled");

  // A stalled output blocks new input transactions.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // With no result waiting, the input side is always open.
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready && cfg_ready)
    else $error("pipeline not ready while output empty");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind smooth_escape_color_core sec_checker u_sec_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the smooth escape color pipeline.
module testbench
  import sec_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = DEF_COORD_FRAC_BITS;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [15:0] iter;
    logic [31:0] zr;
    logic [31:0] zi;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       bad;
  } color_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [15:0] in_iteration_count;
  logic [31:0] in_z_real, in_z_imag;
  logic [7:0] out_red, out_green, out_blue;
  logic out_magnitude_invalid;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  smooth_escape_color_core DUT (.*);

  pixel_t pending_pixels[$];
  color_t expected_colors[$];
  logic [31:0] gain_reg, offset_reg;
  int send_idle, recv_idle;
  int mismatches, cycles, pixels_sent, colors_seen;

  // Fixed-point log2 with 16 fraction bits by repeated squaring.
  function automatic logic [63:0] log2_fix(logic [63:0] v);
    logic [63:0] t, m, fr;
    int e;
    if (v == 0) return 0;
    e = 0;
    t = v;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    fr = 0;
    for (int k = 0; k < LOG_FRAC; k++) begin
      m = (m * m) >> 31;
      fr <<= 1;
      if (m >= 64'h1_0000_0000) begin
        m >>= 1;
        fr |= 1;
      end
    end
    return (64'(e) << LOG_FRAC) | fr;
  endfunction

  // Computes the palette color for one pixel under the current registers.
  function automatic color_t palette_color(pixel_t p);
    logic [63:0] ar, ai, m2, lg, s, y, x, u, a, b, c;
    color_t res;
    ar = p.zr[31] ? 64'(-$signed({32'hFFFF_FFFF, p.zr})) : 64'(p.zr);
    ai = p.zi[31] ? 64'(-$signed({32'hFFFF_FFFF, p.zi})) : 64'(p.zi);
    m2 = ar * ar + ai * ai;
    res.bad = (m2 <= (64'd1 << (2 * FRAC)));
    s = (64'(p.iter) + 1) << LOG_FRAC;
    if (!res.bad) begin
      lg = log2_fix(m2) - (64'(2 * FRAC) << LOG_FRAC);
      if (lg == 0) lg = 1;
      s = s - (log2_fix(lg) - (64'd17 << LOG_FRAC));
    end
    y = s * 64'($signed(gain_reg)) + (64'($signed(offset_reg)) << LOG_FRAC);
    x = (y & ((64'd1 << 40) - 1)) >> 24;
    u = 65536 - x;
    a = (((((x * x) >> 16) * x) >> 16) * u) >> 16;
    b = (((((x * x) >> 16) * u) >> 16) * u) >> 16;
    c = (((((u * u) >> 16) * u) >> 16) * x) >> 16;
    res.red = 8'((a * 2295) >> 16);
    res.green = 8'((b * 3825) >> 16);
    res.blue = 8'((c * 4335) >> 17);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Clock generation.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued pixels, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_colors.push_back(palette_color(
          {in_iteration_count, in_z_real, in_z_imag}));
        pixels_sent++;
      end
      if ((!in_valid || in_ready) && pending_pixels.size() > 0 &&
          $urandom_range(99) >= send_idle) begin
        pixel_t p;
        p = pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_iteration_count <= p.iter;
        in_z_real <= p.zr;
        in_z_imag <= p.zi;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each color transaction with the oldest expectation.
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        colors_seen++;
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected color", 0, 0);
        end else begin
          color_t e;
          e = expected_colors.pop_front();
          if (out_red != e.red) report_mismatch("red", out_red, e.red);
          if (out_green != e.green) report_mismatch("green", out_green, e.green);
          if (out_blue != e.blue) report_mismatch("blue", out_blue, e.blue);
          if (out_magnitude_invalid != e.bad)
            report_mismatch("magnitude_invalid", out_magnitude_invalid, e.bad);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Writes one register while the pipeline is drained.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_COLOR_GAIN) gain_reg = val;
    else offset_reg = val;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || expected_colors.size() > 0)
      @(posedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(33554432)) - 16777216);
      2: return $urandom_range(17000000, 16777000);
      3: return {{6{1'($urandom_range(1))}}, 26'($urandom())};
      default: return 32'($signed($urandom_range(1 << 28)) - (1 << 27));
    endcase
  endfunction

  task automatic queue_random(int n);
    pixel_t p;
    repeat (n) begin
      p.iter = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(200));
      p.zr = rand_coord();
      p.zi = rand_coord();
      pending_pixels.push_back(p);
    end
  endtask

  initial begin
    logic [31:0] gains[6];
    logic [31:0] offs[6];
    gains = '{32'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0004_0000,
              32'hFF00_0000, 32'h0000_0001};
    offs = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0080_0000,
             32'hFFFF_FFFF, 32'h0123_4567};
    rst_n = 0; in_valid = 0; out_ready = 0; cfg_valid = 0; cfg_index = 0;
    cfg_data = 0; in_iteration_count = 0; in_z_real = 0; in_z_imag = 0;
    gain_reg = GAIN_RESET; offset_reg = OFFSET_RESET;
    mismatches = 0; cycles = 0; pixels_sent = 0; colors_seen = 0;
    send_idle = 37; recv_idle = 72;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels: field extremes, unit magnitude and just above it.
    pending_pixels.push_back({16'd0, 32'h0, 32'h0});
    pending_pixels.push_back({16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_pixels.push_back({16'd5, 32'h8000_0000, 32'h8000_0000});
    pending_pixels.push_back({16'd7, 32'h0100_0000, 32'h0});
    pending_pixels.push_back({16'd7, 32'hFF00_0000, 32'h0});
    pending_pixels.push_back({16'd9, 32'h0100_0001, 32'h0});
    pending_pixels.push_back({16'd9, 32'h0, 32'hFEFF_FFFF});
    pending_pixels.push_back({16'd3, 32'h0200_0000, 32'h0200_0000});
    pending_pixels.push_back({16'd1, 32'h00B5_04F3, 32'h00B5_04F4});
    pending_pixels.push_back({16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    drain();

    // Phases through register settings, idling pattern changing over time.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_COLOR_GAIN, gains[ph]);
      write_reg(REG_COLOR_OFFSET, offs[ph]);
      if (ph == 2) begin send_idle = 72; recv_idle = 37; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      queue_random(ph == 0 ? 200 : 150);
      drain();
    end

    $display("Sent %0d pixels through 6 register settings; %0d colors checked.",
             pixels_sent, colors_seen);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
